FILE: rtl/core/depthwise_conv3x3_stride2_pad1_top_macros.svh
// Assertion macros shared by the depthwise 3x3 stride-2 convolution core.
// Include this header from any module that carries concurrent checks.
`ifndef DEPTHWISE_CONV3X3_STRIDE2_PAD1_TOP_MACROS_SVH
`define DEPTHWISE_CONV3X3_STRIDE2_PAD1_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dwc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dwc assertion failed");

`endif

FILE: rtl/core/dwc_pkg.sv
// Shared types and constants of the depthwise 3x3 stride-2 convolution core.
// No dependencies; used by the front end, the MAC datapath and the top level.
`timescale 1ns / 1ps

package dwc_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned KROW_W  = 48;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W  = 32;
  // Nine 32-bit products plus the rounding term fit in 36 bits.
  localparam int unsigned ACC_W   = 36;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KROW0     = 3'd0,
    CFG_KROW1     = 3'd1,
    CFG_KROW2     = 3'd2,
    CFG_BIAS      = 3'd3,
    CFG_CLAMP_MIN = 3'd4,
    CFG_CLAMP_MAX = 3'd5,
    CFG_IMG_WIDTH = 3'd6,
    CFG_PAD_TOP   = 3'd7
  } cfg_idx_e;

  // Result side flags that travel with a window.
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

  // One 3x3 window: tap[row][col], col 0 left, 1 centre, 2 right.
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] tap;
    flags_t                     flags;
  } window_t;

endpackage

FILE: rtl/core/dwc_ram.sv
// Generic two-port RAM with one write port and one registered read port.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps

module dwc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and write-first registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dwc_front.sv
// Front end: column and row tracking, line stores, window registers.
// Depends on dwc_pkg, dwc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "depthwise_conv3x3_stride2_pad1_top_macros.svh"

module dwc_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic [dwc_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              last_row_i,
  input  logic [dwc_pkg::IMG_W_W-1:0]       image_width_i,
  input  logic                              pad_top_i,
  output logic                              win_valid_o,
  output dwc_pkg::window_t                  win_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > dwc_pkg::IMG_W_W) ? CW + 1 : dwc_pkg::IMG_W_W;

  typedef enum logic [1:0] {
    PH_START,
    PH_FIRST0,
    PH_ODD,
    PH_EVEN
  } phase_e;

  phase_e                  phase_q, phase_d, kind;
  logic [CW-1:0]           col_q, col_d;
  logic                    tzf_q, tzf_d, tzf;
  logic [dwc_pkg::PIX_W-1:0] win_left_q [3];
  logic [dwc_pkg::PIX_W-1:0] win_ctr_q  [3];
  logic [dwc_pkg::PIX_W-1:0] cur [3];
  logic [dwc_pkg::PIX_W-1:0] first_rd, middle_rd;
  logic                    accept, start, at_end, odd, emit, col_zero;
  logic [WW-1:0]           w_ext, w_eff, w_m1;
  logic                    win_valid_q;
  dwc_pkg::window_t        win_q, win_d;

  assign accept   = in_valid_i && en_i;
  assign col_zero = (col_q == '0);
  assign odd      = col_q[0];

  // Effective width: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    w_ext = WW'(image_width_i);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_m1   = w_eff - WW'(1);
    at_end = (WW'(col_q) >= w_m1);
  end

  // Row kind, resolved at the first pixel of a frame.
  always_comb begin
    start = col_zero && (phase_q == PH_START);
    if (start) begin
      tzf  = pad_top_i;
      kind = pad_top_i ? PH_ODD : PH_FIRST0;
    end else begin
      tzf  = tzf_q;
      kind = phase_q;
    end
  end

  // Current column of the three kernel rows and the assembled window.
  always_comb begin
    cur[0] = tzf ? '0 : first_rd;
    if (kind == PH_EVEN) begin
      cur[1] = middle_rd;
      cur[2] = pixel_i;
    end else begin
      cur[1] = pixel_i;
      cur[2] = '0;
    end
    emit = (odd || at_end) && ((kind == PH_EVEN) || ((kind == PH_ODD) && last_row_i));
    win_d = '0;
    for (int r = 0; r < 3; r++) begin
      win_d.tap[r][0] = col_zero ? '0 : win_left_q[r];
      win_d.tap[r][1] = odd ? win_ctr_q[r] : cur[r];
      win_d.tap[r][2] = odd ? cur[r] : '0;
    end
    win_d.flags.row_end   = at_end;
    win_d.flags.frame_end = at_end && last_row_i;
  end

  // Next column, phase and top zero flag.
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    tzf_d   = tzf_q;
    if (accept) begin
      tzf_d = tzf;
      if (at_end) begin
        col_d = '0;
        if (kind == PH_EVEN) begin
          tzf_d = 1'b0;
        end
        if (last_row_i) begin
          phase_d = PH_START;
        end else begin
          phase_d = (kind == PH_ODD) ? PH_EVEN : PH_ODD;
        end
      end else begin
        col_d   = col_q + CW'(1);
        phase_d = kind;
      end
    end
  end

  // Control state and window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      phase_q     <= PH_START;
      tzf_q       <= 1'b0;
      win_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_left_q[r] <= '0;
        win_ctr_q[r]  <= '0;
      end
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
      tzf_q   <= tzf_d;
      if (en_i) begin
        win_valid_q <= accept && emit;
      end
      if (accept) begin
        for (int r = 0; r < 3; r++) begin
          if (odd) begin
            win_left_q[r] <= cur[r];
          end else begin
            win_ctr_q[r] <= cur[r];
            if (col_zero) begin
              win_left_q[r] <= '0;
            end
          end
        end
      end
    end
  end

  // Window payload register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win_q <= win_d;
    end
  end

  // Line stores: the read address tracks the next column so data is ready on accept.
  dwc_ram #(
    .WIDTH (dwc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_first_store (
    .clk_i   (clk_i),
    .we_i    (accept && (kind != PH_ODD)),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .raddr_i (col_d),
    .rdata_o (first_rd)
  );

  dwc_ram #(
    .WIDTH (dwc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_store (
    .clk_i   (clk_i),
    .we_i    (accept && (kind == PH_ODD)),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .raddr_i (col_d),
    .rdata_o (middle_rd)
  );

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;

  // A frame always starts at column zero.
  `DWC_ASSERT_NOW(a_start_col_zero, clk_i, rst_ni, phase_q == PH_START, col_q == '0)
  // A window is only produced by an accepted beat.
  `DWC_ASSERT_NEXT(a_win_from_accept, clk_i, rst_ni, en_i && !accept, !win_valid_q)
  // The top zero row is only in effect for a frame that began with padding.
  `DWC_ASSERT_NOW(a_tzf_phase, clk_i, rst_ni, tzf_q, phase_q != PH_FIRST0)

endmodule

FILE: rtl/core/dwc_mac.sv
// MAC datapath: nine products, row sums, rounding shift, bias, clamp, result register.
// Depends on dwc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "depthwise_conv3x3_stride2_pad1_top_macros.svh"

module dwc_mac #(
  parameter int unsigned WEIGHT_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              win_valid_i,
  input  dwc_pkg::window_t                  win_i,
  input  logic [2:0][2:0][dwc_pkg::PIX_W-1:0] weight_i,
  input  logic signed [dwc_pkg::PIX_W-1:0]  bias_i,
  input  logic signed [dwc_pkg::PIX_W-1:0]  clamp_min_i,
  input  logic signed [dwc_pkg::PIX_W-1:0]  clamp_max_i,
  input  logic                              out_ready_i,
  output logic                              en_o,
  output logic                              out_valid_o,
  output logic [dwc_pkg::PIX_W-1:0]         out_value_o,
  output logic                              out_row_end_o,
  output logic                              out_frame_end_o
);

  localparam int unsigned AW = dwc_pkg::ACC_W;
  localparam int unsigned VW = AW + 1;
  // Half an LSB of the shifted result, zero when there are no fraction bits.
  localparam logic signed [AW-1:0] RND = (AW'(1) << WEIGHT_FRAC_BITS) >> 1;

  logic                               en;
  logic                               p_valid_q, r_valid_q, t_valid_q, o_valid_q;
  dwc_pkg::flags_t                    p_flags_q, r_flags_q, t_flags_q, o_flags_q;
  logic signed [dwc_pkg::PROD_W-1:0]  prod_q [3][3];
  logic signed [AW-1:0]               rsum_q [3];
  logic signed [AW-1:0]               rsum_d [3];
  logic signed [AW-1:0]               total;
  logic signed [AW-1:0]               shifted;
  logic signed [VW-1:0]               tval_q, tval_d;
  logic signed [VW-1:0]               cmin_ext, cmax_ext, vlo, vhi;
  logic [dwc_pkg::PIX_W-1:0]          o_value_q;

  // The whole pipeline moves whenever the result register is free or being taken.
  assign en   = !o_valid_q || out_ready_i;
  assign en_o = en;

  // Row sums, with the rounding term folded into the top row.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_d[r] = AW'(prod_q[r][0]) + AW'(prod_q[r][1]) + AW'(prod_q[r][2]);
    end
    rsum_d[0] = rsum_d[0] + RND;
  end

  // Total, arithmetic shift and bias.
  always_comb begin
    total   = rsum_q[0] + rsum_q[1] + rsum_q[2];
    shifted = total >>> WEIGHT_FRAC_BITS;
    tval_d  = VW'(shifted) + VW'(bias_i);
  end

  // Clamp to the lower bound first, then to the upper bound.
  always_comb begin
    cmin_ext = VW'(clamp_min_i);
    cmax_ext = VW'(clamp_max_i);
    vlo = (tval_q < cmin_ext) ? cmin_ext : tval_q;
    vhi = (vlo > cmax_ext) ? cmax_ext : vlo;
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      t_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= win_valid_i;
      r_valid_q <= p_valid_q;
      t_valid_q <= r_valid_q;
      o_valid_q <= t_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= $signed(win_i.tap[r][k]) * $signed(weight_i[r][k]);
        end
        rsum_q[r] <= rsum_d[r];
      end
      p_flags_q <= win_i.flags;
      r_flags_q <= p_flags_q;
      tval_q    <= tval_d;
      t_flags_q <= r_flags_q;
      o_value_q <= vhi[dwc_pkg::PIX_W-1:0];
      o_flags_q <= t_flags_q;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign out_value_o     = o_value_q;
  assign out_row_end_o   = o_flags_q.row_end;
  assign out_frame_end_o = o_flags_q.frame_end;

  // A frame ends only on the last result of a row.
  `DWC_ASSERT_NOW(a_frame_end_row_end, clk_i, rst_ni, o_valid_q && o_flags_q.frame_end,
                  o_flags_q.row_end)
  // With ordered bounds the result lies between them.
  `DWC_ASSERT_NOW(a_clamp_range, clk_i, rst_ni, o_valid_q && (clamp_min_i <= clamp_max_i),
                  ($signed(o_value_q) >= clamp_min_i) && ($signed(o_value_q) <= clamp_max_i))
  // A stalled pipeline keeps its inner stages in place.
  `DWC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en,
                   $stable(t_valid_q) && $stable(r_valid_q) && $stable(p_valid_q))

endmodule

FILE: rtl/core/depthwise_conv3x3_stride2_pad1_top.sv
// A result beat passes the front-end window register, then the MAC product, row sum, total and result registers.
// Throughput: one pixel per cycle while not stalled; rows that emit give one result per two pixels.
// The pipeline and input ready stall together only while a result waits to be taken.
// Reset (async, active low) clears control state and loads the register reset values.
// The line stores are not cleared; each entry is written before it is read.
// Depends on dwc_pkg, dwc_front, dwc_mac and dwc_ram.
`timescale 1ns / 1ps

module depthwise_conv3x3_stride2_pad1_top #(
  parameter int unsigned MAX_WIDTH        = 1024,
  parameter int unsigned WEIGHT_FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dwc_pkg::KROW_W-1:0]      cfg_wdata_i,
  // Pixel stream in.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [15:0]                     s_axis_tdata_i,   // [15:0] pixel
  input  logic                            s_axis_tuser_i,   // [0] last_row
  // Result stream out.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [15:0]                     m_axis_tdata_o,   // [15:0] value
  output logic                            m_axis_tlast_o,   // row_end
  output logic                            m_axis_tuser_o    // [0] frame_end
);

  logic [dwc_pkg::KROW_W-1:0]          krow_q [3];
  logic signed [dwc_pkg::PIX_W-1:0]    bias_q, cmin_q, cmax_q;
  logic [dwc_pkg::IMG_W_W-1:0]         img_width_q;
  logic                                pad_top_q;
  logic [2:0][2:0][dwc_pkg::PIX_W-1:0] weight;
  logic                                en, win_valid;
  dwc_pkg::window_t                    win;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        krow_q[r] <= '0;
      end
      bias_q      <= '0;
      cmin_q      <= 16'sh8000;
      cmax_q      <= 16'sh7fff;
      img_width_q <= dwc_pkg::IMG_W_W'(1024);
      pad_top_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (dwc_pkg::cfg_idx_e'(cfg_index_i))
        dwc_pkg::CFG_KROW0:     krow_q[0]   <= cfg_wdata_i;
        dwc_pkg::CFG_KROW1:     krow_q[1]   <= cfg_wdata_i;
        dwc_pkg::CFG_KROW2:     krow_q[2]   <= cfg_wdata_i;
        dwc_pkg::CFG_BIAS:      bias_q      <= cfg_wdata_i[dwc_pkg::PIX_W-1:0];
        dwc_pkg::CFG_CLAMP_MIN: cmin_q      <= cfg_wdata_i[dwc_pkg::PIX_W-1:0];
        dwc_pkg::CFG_CLAMP_MAX: cmax_q      <= cfg_wdata_i[dwc_pkg::PIX_W-1:0];
        dwc_pkg::CFG_IMG_WIDTH: img_width_q <= cfg_wdata_i[dwc_pkg::IMG_W_W-1:0];
        dwc_pkg::CFG_PAD_TOP:   pad_top_q   <= cfg_wdata_i[0];
      endcase
    end
  end

  // Unpack the kernel rows, column 0 in the low bits.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        weight[r][k] = krow_q[r][dwc_pkg::PIX_W*k +: dwc_pkg::PIX_W];
      end
    end
  end

  assign s_axis_tready_o = en;

  dwc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (s_axis_tvalid_i),
    .pixel_i       (s_axis_tdata_i),
    .last_row_i    (s_axis_tuser_i),
    .image_width_i (img_width_q),
    .pad_top_i     (pad_top_q),
    .win_valid_o   (win_valid),
    .win_o         (win)
  );

  dwc_mac #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_valid_i     (win_valid),
    .win_i           (win),
    .weight_i        (weight),
    .bias_i          (bias_q),
    .clamp_min_i     (cmin_q),
    .clamp_max_i     (cmax_q),
    .out_ready_i     (m_axis_tready_i),
    .en_o            (en),
    .out_valid_o     (m_axis_tvalid_o),
    .out_value_o     (m_axis_tdata_o),
    .out_row_end_o   (m_axis_tlast_o),
    .out_frame_end_o (m_axis_tuser_o)
  );

endmodule
